[rtl/bsfd_pkg.sv]
// Shared constants, register codes and configuration type for the balance drive.
package bsfd_pkg;

   // Data path defaults and fixed field widths
   localparam int DATA_WIDTH_DEF   = 16;
   localparam int GAIN_WIDTH       = 16;
   localparam int LIMIT_WIDTH      = 15;
   localparam int STEP_WIDTH       = 16;
   localparam int HEIGHT_WIDTH     = 8;
   localparam int POS_WIDTH        = 32;
   localparam int COEF_WIDTH       = 18;
   localparam int CSR_INDEX_WIDTH  = 4;
   localparam int CSR_DATA_WIDTH   = 16;
   localparam int QUEUE_DEPTH      = 2;

   // Scaling constants in Q1.16, and the plain body height threshold
   localparam int HEIGHT_THRESHOLD = 80;
   localparam int BOOST_Q16        = 75366;
   localparam int STEER_Q16        = 45875;

   // Configuration register indexes
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_GAIN_ANGLE      = 4'd0,
      REG_GAIN_RATE       = 4'd1,
      REG_GAIN_POSITION   = 4'd2,
      REG_GAIN_VELOCITY   = 4'd3,
      REG_TARGET_ANGLE    = 4'd4,
      REG_TARGET_POSITION = 4'd5,
      REG_DRIVE_LIMIT     = 4'd6,
      REG_TIME_STEP       = 4'd7
   } bsfd_reg_type;

   // Register reset values
   localparam logic signed [GAIN_WIDTH-1:0] RST_GAIN_ANGLE      = -16'sd8095;
   localparam logic signed [GAIN_WIDTH-1:0] RST_GAIN_RATE       = -16'sd1144;
   localparam logic signed [GAIN_WIDTH-1:0] RST_GAIN_POSITION   = -16'sd443;
   localparam logic signed [GAIN_WIDTH-1:0] RST_GAIN_VELOCITY   = -16'sd573;
   localparam logic signed [GAIN_WIDTH-1:0] RST_TARGET_ANGLE    = 16'sd0;
   localparam logic signed [GAIN_WIDTH-1:0] RST_TARGET_POSITION = 16'sd0;
   localparam logic [LIMIT_WIDTH-1:0]       RST_DRIVE_LIMIT     = 15'd1280;
   localparam logic [STEP_WIDTH-1:0]        RST_TIME_STEP       = 16'd655;

   // Configuration as seen by the data path
   typedef struct packed {
      logic signed [GAIN_WIDTH-1:0] gain_angle;
      logic signed [GAIN_WIDTH-1:0] gain_rate;
      logic signed [GAIN_WIDTH-1:0] gain_position;
      logic signed [GAIN_WIDTH-1:0] gain_velocity;
      logic signed [GAIN_WIDTH-1:0] target_angle;
      logic signed [GAIN_WIDTH-1:0] target_position;
      logic [LIMIT_WIDTH-1:0]       drive_limit;
      logic [STEP_WIDTH-1:0]        time_step;
   } bsfd_cfg_type;

endpackage

[rtl/bsfd_csr.sv]
// Configuration register file of the balance drive.
module bsfd_csr
   import bsfd_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata,
   output bsfd_cfg_type               cfg
);

   bsfd_cfg_type cfg_ff;
   bsfd_cfg_type cfg_in;

   // Always take writes; block is idle when software writes, a rule the block does not enforce
   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Decode the register index, drop writes beyond the list
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_GAIN_ANGLE:      cfg_in.gain_angle      = csr_wdata;
            REG_GAIN_RATE:       cfg_in.gain_rate       = csr_wdata;
            REG_GAIN_POSITION:   cfg_in.gain_position   = csr_wdata;
            REG_GAIN_VELOCITY:   cfg_in.gain_velocity   = csr_wdata;
            REG_TARGET_ANGLE:    cfg_in.target_angle    = csr_wdata;
            REG_TARGET_POSITION: cfg_in.target_position = csr_wdata;
            REG_DRIVE_LIMIT:     cfg_in.drive_limit     = csr_wdata[LIMIT_WIDTH-1:0];
            REG_TIME_STEP:       cfg_in.time_step       = csr_wdata[STEP_WIDTH-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_angle      <= RST_GAIN_ANGLE;
         cfg_ff.gain_rate       <= RST_GAIN_RATE;
         cfg_ff.gain_position   <= RST_GAIN_POSITION;
         cfg_ff.gain_velocity   <= RST_GAIN_VELOCITY;
         cfg_ff.target_angle    <= RST_TARGET_ANGLE;
         cfg_ff.target_position <= RST_TARGET_POSITION;
         cfg_ff.drive_limit     <= RST_DRIVE_LIMIT;
         cfg_ff.time_step       <= RST_TIME_STEP;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[rtl/bsfd_queue.sv]
// Small register queue between the request front end and the compute back end.
module bsfd_queue
   import bsfd_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             push_ready,
   input  logic             pop,
   output logic             pop_valid,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entries_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[rtl/bsfd_front.sv]
// Request front end: forms the error terms and the height class of each tick.
module bsfd_front
   import bsfd_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic signed [DATA_WIDTH-1:0] req_pitch_angle,
   input  logic signed [DATA_WIDTH-1:0] req_pitch_trim,
   input  logic signed [DATA_WIDTH-1:0] req_pitch_rate,
   input  logic signed [DATA_WIDTH-1:0] req_left_speed,
   input  logic signed [DATA_WIDTH-1:0] req_right_speed,
   input  logic signed [DATA_WIDTH-1:0] req_forward_command,
   input  logic signed [DATA_WIDTH-1:0] req_steer_command,
   input  logic [HEIGHT_WIDTH-1:0]      req_body_height,
   input  logic signed [GAIN_WIDTH-1:0] target_angle,
   // {steer, vel_err, rate, angle_err, wheel_sum, boost}
   output logic [5*DATA_WIDTH+1:0]      entry
);

   localparam int EW = ((DATA_WIDTH > GAIN_WIDTH) ? DATA_WIDTH : GAIN_WIDTH) + 2;
   localparam logic signed [EW-1:0] DMAX = EW'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
   localparam logic signed [EW-1:0] DMIN = EW'(-(64'sd1 <<< (DATA_WIDTH - 1)));

   logic signed [DATA_WIDTH:0]   wheel_sum;
   logic signed [DATA_WIDTH:0]   wheel_mean;
   logic signed [EW-1:0]         angle_raw;
   logic signed [EW-1:0]         vel_raw;
   logic signed [DATA_WIDTH-1:0] angle_err;
   logic signed [DATA_WIDTH-1:0] vel_err;
   logic                         boost;

   function automatic logic signed [DATA_WIDTH-1:0] sat_data(input logic signed [EW-1:0] x);
      logic signed [DATA_WIDTH-1:0] r;
      if (x > DMAX) begin
         r = DMAX[DATA_WIDTH-1:0];
      end else if (x < DMIN) begin
         r = DMIN[DATA_WIDTH-1:0];
      end else begin
         r = x[DATA_WIDTH-1:0];
      end
      return r;
   endfunction

   // Mean wheel speed rounds toward minus infinity
   assign wheel_sum  = (DATA_WIDTH+1)'(req_left_speed) + (DATA_WIDTH+1)'(req_right_speed);
   assign wheel_mean = wheel_sum >>> 1;

   // Error terms, clipped to the data range
   assign angle_raw = EW'(req_pitch_angle) - EW'(req_pitch_trim) - EW'(target_angle);
   assign vel_raw   = EW'(wheel_mean) - EW'(req_forward_command);
   assign angle_err = sat_data(angle_raw);
   assign vel_err   = sat_data(vel_raw);

   // Tall stance gets the drive boost
   assign boost = (req_body_height > HEIGHT_WIDTH'(HEIGHT_THRESHOLD));

   assign entry = {req_steer_command, vel_err, req_pitch_rate, angle_err, wheel_sum, boost};

endmodule

[rtl/bsfd_back.sv]
// Compute back end: one shared multiplier stepped through the feedback law.
module bsfd_back
   import bsfd_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  bsfd_cfg_type                 cfg,
   input  logic                         q_valid,
   input  logic [5*DATA_WIDTH+1:0]      q_data,
   output logic                         q_pop,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [DATA_WIDTH-1:0] rsp_left_drive,
   output logic signed [DATA_WIDTH-1:0] rsp_right_drive,
   output logic                         rsp_limited
);

   localparam int DW  = DATA_WIDTH;
   localparam int QW  = 5 * DW + 2;
   localparam int MA  = DW + 2;           // multiplier operand A
   localparam int PW  = MA + COEF_WIDTH;  // product
   localparam int SW  = PW + 1;           // integrator sum
   localparam int AW  = DW + 18;          // feedback accumulator
   localparam int VW  = AW + 1;
   localparam int EPW = DW + 24;          // position error
   localparam int CW  = DW + 6;           // wheel mix and clamp

   localparam logic signed [SW-1:0]  POS_MAX = SW'(64'sd2147483647);
   localparam logic signed [SW-1:0]  POS_MIN = SW'(-64'sd2147483648);
   localparam logic signed [EPW-1:0] DMAX_E  = EPW'((64'sd1 <<< (DW - 1)) - 64'sd1);
   localparam logic signed [EPW-1:0] DMIN_E  = EPW'(-(64'sd1 <<< (DW - 1)));
   localparam logic signed [VW-1:0]  UMAX    = VW'(64'sd1 <<< DW);
   localparam logic signed [VW-1:0]  UMIN    = VW'(-(64'sd1 <<< DW));
   localparam logic signed [CW-1:0]  DMAX_C  = CW'((64'sd1 <<< (DW - 1)) - 64'sd1);
   localparam logic signed [CW-1:0]  DMIN_C  = CW'(-(64'sd1 <<< (DW - 1)));

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INT,
      ST_EPOS,
      ST_PTERM,
      ST_VTERM,
      ST_USUM,
      ST_UCALC,
      ST_BOOST,
      ST_SCALE,
      ST_MIX
   } state_type;

   state_type                    state_ff, state_in;
   logic [QW-1:0]                entry_ff, entry_in;
   logic signed [PW-1:0]         prod_ff, prod_in;
   logic signed [POS_WIDTH-1:0]  pos_ff, pos_in;
   logic signed [DW-1:0]         epos_ff, epos_in;
   logic signed [AW-1:0]         acc_ff, acc_in;
   logic signed [MA-1:0]         u_ff, u_in;
   logic signed [DW-1:0]         st_ff, st_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [DW-1:0]         left_ff, left_in;
   logic signed [DW-1:0]         right_ff, right_in;
   logic                         limited_ff, limited_in;

   logic signed [DW:0]           e_sum;
   logic signed [DW-1:0]         e_ang, e_rate, e_vel, e_steer;
   logic                         e_boost;
   logic signed [DW:0]           q_sum;
   logic signed [MA-1:0]         mul_a;
   logic signed [COEF_WIDTH-1:0] mul_b;
   logic signed [SW-1:0]         delta, pos_sum;
   logic signed [POS_WIDTH:0]    pos_round;
   logic signed [EPW-1:0]        epos_raw;
   logic signed [VW-1:0]         u_neg, u_shift;
   logic signed [PW-1:0]         prod_round;
   logic signed [CW-1:0]         wl, wr, lim_s, hi, lo;
   logic                         out_free;

   // Unpack the queued request
   assign e_boost = entry_ff[0];
   assign e_sum   = entry_ff[DW+1:1];
   assign e_ang   = entry_ff[2*DW+1:DW+2];
   assign e_rate  = entry_ff[3*DW+1:2*DW+2];
   assign e_vel   = entry_ff[4*DW+1:3*DW+2];
   assign e_steer = entry_ff[5*DW+1:4*DW+2];
   assign q_sum   = q_data[DW+1:1];

   assign q_pop    = (state_ff == ST_IDLE) && q_valid;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Select the multiplier operands for this step
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_IDLE: begin
            mul_a = MA'(q_sum);
            mul_b = COEF_WIDTH'($signed({1'b0, cfg.time_step}));
         end
         ST_INT: begin
            mul_a = MA'(e_ang);
            mul_b = COEF_WIDTH'(cfg.gain_angle);
         end
         ST_EPOS: begin
            mul_a = MA'(e_rate);
            mul_b = COEF_WIDTH'(cfg.gain_rate);
         end
         ST_PTERM: begin
            mul_a = MA'(epos_ff);
            mul_b = COEF_WIDTH'(cfg.gain_position);
         end
         ST_VTERM: begin
            mul_a = MA'(e_vel);
            mul_b = COEF_WIDTH'(cfg.gain_velocity);
         end
         ST_UCALC: begin
            mul_a = MA'(e_steer);
            mul_b = COEF_WIDTH'(STEER_Q16);
         end
         ST_BOOST: begin
            mul_a = u_ff;
            mul_b = COEF_WIDTH'(BOOST_Q16);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Integrator step with half-up rounding, held at the 32-bit limits
   assign delta   = (SW'(prod_ff) + SW'(256)) >>> 9;
   assign pos_sum = SW'(pos_ff) + delta;

   // Position error from the integrator, back to data scale
   assign pos_round = ((POS_WIDTH+1)'(pos_ff) + (POS_WIDTH+1)'(128)) >>> 8;
   assign epos_raw  = EPW'(pos_round) - EPW'(cfg.target_position);

   // Negated feedback sum, rounded and bounded
   assign u_neg   = VW'(128) - VW'(acc_ff);
   assign u_shift = u_neg >>> 8;

   // Q1.16 product rounding
   assign prod_round = (prod_ff + PW'(32768)) >>> 16;

   // Wheel mix and bounds
   assign wl    = CW'(u_ff) - CW'(st_ff);
   assign wr    = CW'(u_ff) + CW'(st_ff);
   assign lim_s = CW'($signed({1'b0, cfg.drive_limit}));
   assign hi    = (lim_s < DMAX_C) ? lim_s : DMAX_C;
   assign lo    = (-lim_s > DMIN_C) ? -lim_s : DMIN_C;

   // Step the sequencer
   always_comb begin
      state_in     = state_ff;
      entry_in     = entry_ff;
      prod_in      = mul_a * mul_b;
      pos_in       = pos_ff;
      epos_in      = epos_ff;
      acc_in       = acc_ff;
      u_in         = u_ff;
      st_in        = st_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      left_in      = left_ff;
      right_in     = right_ff;
      limited_in   = limited_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               entry_in = q_data;
               state_in = ST_INT;
            end
         end
         ST_INT: begin
            if (pos_sum > POS_MAX) begin
               pos_in = POS_MAX[POS_WIDTH-1:0];
            end else if (pos_sum < POS_MIN) begin
               pos_in = POS_MIN[POS_WIDTH-1:0];
            end else begin
               pos_in = pos_sum[POS_WIDTH-1:0];
            end
            state_in = ST_EPOS;
         end
         ST_EPOS: begin
            if (epos_raw > DMAX_E) begin
               epos_in = DMAX_E[DW-1:0];
            end else if (epos_raw < DMIN_E) begin
               epos_in = DMIN_E[DW-1:0];
            end else begin
               epos_in = epos_raw[DW-1:0];
            end
            acc_in   = AW'(prod_ff);
            state_in = ST_PTERM;
         end
         ST_PTERM: begin
            acc_in   = acc_ff + AW'(prod_ff);
            state_in = ST_VTERM;
         end
         ST_VTERM: begin
            acc_in   = acc_ff + AW'(prod_ff);
            state_in = ST_USUM;
         end
         ST_USUM: begin
            acc_in   = acc_ff + AW'(prod_ff);
            state_in = ST_UCALC;
         end
         ST_UCALC: begin
            if (u_shift > UMAX) begin
               u_in = UMAX[MA-1:0];
            end else if (u_shift < UMIN) begin
               u_in = UMIN[MA-1:0];
            end else begin
               u_in = u_shift[MA-1:0];
            end
            state_in = ST_BOOST;
         end
         ST_BOOST: begin
            st_in    = prod_round[DW-1:0];
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            if (e_boost) begin
               u_in = prod_round[MA-1:0];
            end
            state_in = ST_MIX;
         end
         ST_MIX: begin
            // Wait for the output register to drain
            if (out_free) begin
               rsp_valid_in = 1'b1;
               left_in      = (wl > hi) ? hi[DW-1:0] : ((wl < lo) ? lo[DW-1:0] : wl[DW-1:0]);
               right_in     = (wr > hi) ? hi[DW-1:0] : ((wr < lo) ? lo[DW-1:0] : wr[DW-1:0]);
               limited_in   = (wl > hi) || (wl < lo) || (wr > hi) || (wr < lo);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff   <= entry_in;
      prod_ff    <= prod_in;
      epos_ff    <= epos_in;
      acc_ff     <= acc_in;
      u_ff       <= u_in;
      st_ff      <= st_in;
      left_ff    <= left_in;
      right_ff   <= right_in;
      limited_ff <= limited_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_left_drive  = left_ff;
   assign rsp_right_drive = right_ff;
   assign rsp_limited     = limited_ff;

endmodule

[rtl/balance_state_feedback_drive.sv]
// Top level of the balance state-feedback wheel drive.
//
//   channel | direction | handshake          | payload
//   req_    | in        | req_valid/req_stall| pitch, trim, rate, wheel speeds, commands, height
//   rsp_    | out       | rsp_valid/rsp_stall| left_drive, right_drive, limited
//   csr_    | in        | csr_valid/csr_ready| csr_index, csr_wdata
//
// A request steps the back end through the ten states of its shared multiplier
// sequence; the back end takes the next request only once the last has left it.
// A two-entry queue takes up to two requests while the back end works.
// Synchronous reset restores register defaults and clears the position integrator.
// rsp_stall holds the result register; the back end then waits in its last step
// and req_stall rises once the queue is full.
module balance_state_feedback_drive
   import bsfd_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [DATA_WIDTH-1:0] req_pitch_angle,
   input  logic signed [DATA_WIDTH-1:0] req_pitch_trim,
   input  logic signed [DATA_WIDTH-1:0] req_pitch_rate,
   input  logic signed [DATA_WIDTH-1:0] req_left_speed,
   input  logic signed [DATA_WIDTH-1:0] req_right_speed,
   input  logic signed [DATA_WIDTH-1:0] req_forward_command,
   input  logic signed [DATA_WIDTH-1:0] req_steer_command,
   input  logic [HEIGHT_WIDTH-1:0]      req_body_height,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [DATA_WIDTH-1:0] rsp_left_drive,
   output logic signed [DATA_WIDTH-1:0] rsp_right_drive,
   output logic                         rsp_limited,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]    csr_wdata
);

   localparam int QW = 5 * DATA_WIDTH + 2;

   bsfd_cfg_type  cfg;
   logic [QW-1:0] front_entry;
   logic [QW-1:0] q_data;
   logic          q_push_ready;
   logic          q_valid;
   logic          q_pop;

   // Hold requests while the queue is full
   assign req_stall = !q_push_ready;

   bsfd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bsfd_front #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_front (
      .req_pitch_angle     (req_pitch_angle),
      .req_pitch_trim      (req_pitch_trim),
      .req_pitch_rate      (req_pitch_rate),
      .req_left_speed      (req_left_speed),
      .req_right_speed     (req_right_speed),
      .req_forward_command (req_forward_command),
      .req_steer_command   (req_steer_command),
      .req_body_height     (req_body_height),
      .target_angle        (cfg.target_angle),
      .entry               (front_entry)
   );

   bsfd_queue #(
      .WIDTH (QW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_valid && !req_stall),
      .push_data  (front_entry),
      .push_ready (q_push_ready),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_data   (q_data)
   );

   bsfd_back #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .q_valid         (q_valid),
      .q_data          (q_data),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_left_drive  (rsp_left_drive),
      .rsp_right_drive (rsp_right_drive),
      .rsp_limited     (rsp_limited)
   );

endmodule

[rtl/bsfd_checker.sv]
// Port-level checks of the balance drive, bound to the top level.
module bsfd_checker
   import bsfd_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic signed [DATA_WIDTH-1:0] rsp_left_drive,
   input logic signed [DATA_WIDTH-1:0] rsp_right_drive,
   input logic                         rsp_limited,
   input logic                         csr_ready
);

   // Reset drops any pending result
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // Reset empties the queue, so requests are taken at once
   assert property (@(posedge clock) reset |=> !req_stall)
      else $error("request stalled right after reset");

   // A stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_left_drive)
         && $stable(rsp_right_drive) && $stable(rsp_limited))
      else $error("stalled result changed");

   // Register writes are never refused
   assert property (@(posedge clock) csr_ready)
      else $error("configuration port not ready");

endmodule

bind balance_state_feedback_drive bsfd_checker #(.DATA_WIDTH(DATA_WIDTH)) u_bsfd_checker (.*);

[tb/balance_state_feedback_drive_test.sv]
// Self-checking testbench for the balance state-feedback wheel drive.
module balance_state_feedback_drive_test;
   timeunit 1ns;
   timeprecision 1ps;
   import bsfd_pkg::*;

   localparam int DW = DATA_WIDTH_DEF;
   localparam longint DATA_MAX = (longint'(1) <<< (DW - 1)) - 1;
   localparam longint DATA_MIN = -DATA_MAX - 1;
   localparam longint POS_MAX = (longint'(1) <<< (POS_WIDTH - 1)) - 1;
   localparam longint POS_MIN = -POS_MAX - 1;
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int END_SETTLE = 40;

   typedef struct packed {
      logic signed [DW-1:0]    pitch_angle;
      logic signed [DW-1:0]    pitch_trim;
      logic signed [DW-1:0]    pitch_rate;
      logic signed [DW-1:0]    left_speed;
      logic signed [DW-1:0]    right_speed;
      logic signed [DW-1:0]    forward_command;
      logic signed [DW-1:0]    steer_command;
      logic [HEIGHT_WIDTH-1:0] body_height;
   } tick_type;

   typedef struct packed {
      logic signed [DW-1:0] left_drive;
      logic signed [DW-1:0] right_drive;
      logic                 limited;
   } drive_type;

   typedef enum int {MIX_TICKS, CLIMB_TICKS, DESCEND_TICKS} tick_style_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   tick_type req_item = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [DW-1:0] rsp_left_drive;
   logic signed [DW-1:0] rsp_right_drive;
   logic rsp_limited;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_wdata = '0;

   tick_type pending_ticks[$];
   drive_type expected_drives[$];
   bsfd_cfg_type cfg_model;
   bsfd_cfg_type settings;
   longint position_model;
   logic req_taken = 1'b0;
   int idle_pct = 0;
   int send_gap = 0;
   int hold_gap = 0;
   int fail_count = 0;
   int unsigned cycle_count = 0;

   balance_state_feedback_drive #(.DATA_WIDTH(DW)) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_pitch_angle(req_item.pitch_angle),
      .req_pitch_trim(req_item.pitch_trim),
      .req_pitch_rate(req_item.pitch_rate),
      .req_left_speed(req_item.left_speed),
      .req_right_speed(req_item.right_speed),
      .req_forward_command(req_item.forward_command),
      .req_steer_command(req_item.steer_command),
      .req_body_height(req_item.body_height),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_left_drive(rsp_left_drive),
      .rsp_right_drive(rsp_right_drive),
      .rsp_limited(rsp_limited),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #5ns clock = ~clock;

   function automatic longint clip(input longint x, input longint lo, input longint hi);
      return x < lo ? lo : (x > hi ? hi : x);
   endfunction

   // Advance the integrator and work out the wheel drives for one tick
   function automatic drive_type predict_drive(input tick_type t);
      longint sum, delta, e_ang, e_pos, e_vel, acc, u, st, wl, wr, lim, hi, lo;
      drive_type r;
      sum = longint'(t.left_speed) + longint'(t.right_speed);
      delta = (sum * longint'(cfg_model.time_step) + 256) >>> 9;
      position_model = clip(position_model + delta, POS_MIN, POS_MAX);

      e_ang = clip(longint'(t.pitch_angle) - longint'(t.pitch_trim)
                   - longint'(cfg_model.target_angle), DATA_MIN, DATA_MAX);
      e_pos = clip(((position_model + 128) >>> 8) - longint'(cfg_model.target_position),
                   DATA_MIN, DATA_MAX);
      e_vel = clip((sum >>> 1) - longint'(t.forward_command), DATA_MIN, DATA_MAX);

      acc = longint'(cfg_model.gain_angle) * e_ang
          + longint'(cfg_model.gain_rate) * longint'(t.pitch_rate)
          + longint'(cfg_model.gain_position) * e_pos
          + longint'(cfg_model.gain_velocity) * e_vel;
      u = (128 - acc) >>> 8;
      u = clip(u, -(longint'(1) <<< DW), longint'(1) <<< DW);
      // Boost drive for a raised body
      if (t.body_height > HEIGHT_THRESHOLD)
         u = (u * BOOST_Q16 + 32768) >>> 16;

      st = (longint'(t.steer_command) * STEER_Q16 + 32768) >>> 16;
      wl = u - st;
      wr = u + st;

      // Clamp each wheel; a value sitting on a bound is not flagged
      lim = longint'(cfg_model.drive_limit);
      hi = lim < DATA_MAX ? lim : DATA_MAX;
      lo = -lim > DATA_MIN ? -lim : DATA_MIN;
      r.limited = (wl > hi) || (wl < lo) || (wr > hi) || (wr < lo);
      r.left_drive = DW'(clip(wl, lo, hi));
      r.right_drive = DW'(clip(wr, lo, hi));
      return r;
   endfunction

   function automatic logic [DW-1:0] draw_field();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: return DW'(int'($urandom_range(0, 4095)) - 2048);
         6, 7: return DW'($urandom);
         8: return $urandom_range(0, 1) ? DW'(DATA_MAX) : DW'(DATA_MIN);
         default: return DW'(int'($urandom_range(0, 2)) - 1);
      endcase
   endfunction

   function automatic tick_type random_tick(input tick_style_type style);
      tick_type t;
      t.pitch_angle = draw_field();
      t.pitch_trim = draw_field();
      t.pitch_rate = draw_field();
      t.left_speed = draw_field();
      t.right_speed = draw_field();
      t.forward_command = draw_field();
      t.steer_command = draw_field();
      t.body_height = ($urandom_range(0, 3) == 0) ? HEIGHT_WIDTH'($urandom_range(78, 83))
                                                  : HEIGHT_WIDTH'($urandom);
      // Push both wheels hard one way to wind the integrator into saturation
      if (style == CLIMB_TICKS) begin
         t.left_speed = DW'(DATA_MAX - $urandom_range(0, 255));
         t.right_speed = DW'(DATA_MAX - $urandom_range(0, 255));
      end else if (style == DESCEND_TICKS) begin
         t.left_speed = DW'(DATA_MIN + $urandom_range(0, 255));
         t.right_speed = DW'(DATA_MIN + $urandom_range(0, 255));
      end
      return t;
   endfunction

   function automatic logic [15:0] draw_setting(input logic [15:0] usual);
      case ($urandom_range(0, 5))
         0, 1, 2: return usual + 16'($urandom_range(0, 64)) - 16'd32;
         3: return 16'($urandom);
         4: return 16'h7FFF;
         default: return $urandom_range(0, 1) ? 16'h8000 : 16'hFFFF;
      endcase
   endfunction

   function automatic bsfd_cfg_type random_settings();
      bsfd_cfg_type s;
      s.gain_angle = draw_setting(RST_GAIN_ANGLE);
      s.gain_rate = draw_setting(RST_GAIN_RATE);
      s.gain_position = draw_setting(RST_GAIN_POSITION);
      s.gain_velocity = draw_setting(RST_GAIN_VELOCITY);
      s.target_angle = draw_setting(RST_TARGET_ANGLE);
      s.target_position = draw_setting(RST_TARGET_POSITION);
      s.drive_limit = LIMIT_WIDTH'(draw_setting(16'(RST_DRIVE_LIMIT)));
      s.time_step = draw_setting(RST_TIME_STEP);
      return s;
   endfunction

   function automatic void add_tick(input longint pa, input longint pt, input longint pr,
                                    input longint ls, input longint rs, input longint fw,
                                    input longint st, input int h);
      tick_type t;
      t.pitch_angle = DW'(pa);
      t.pitch_trim = DW'(pt);
      t.pitch_rate = DW'(pr);
      t.left_speed = DW'(ls);
      t.right_speed = DW'(rs);
      t.forward_command = DW'(fw);
      t.steer_command = DW'(st);
      t.body_height = HEIGHT_WIDTH'(h);
      pending_ticks.push_back(t);
   endfunction

   // Write one register; called at a falling edge, returns at a falling edge
   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      case (idx)
         REG_GAIN_ANGLE:      cfg_model.gain_angle = data;
         REG_GAIN_RATE:       cfg_model.gain_rate = data;
         REG_GAIN_POSITION:   cfg_model.gain_position = data;
         REG_GAIN_VELOCITY:   cfg_model.gain_velocity = data;
         REG_TARGET_ANGLE:    cfg_model.target_angle = data;
         REG_TARGET_POSITION: cfg_model.target_position = data;
         REG_DRIVE_LIMIT:     cfg_model.drive_limit = data[LIMIT_WIDTH-1:0];
         REG_TIME_STEP:       cfg_model.time_step = data;
         default: ;
      endcase
      @(negedge clock);
   endtask

   // Load a full setting, with a write to an unused index thrown in
   task automatic load_settings(input bsfd_cfg_type s);
      write_reg(REG_GAIN_ANGLE, s.gain_angle);
      write_reg(REG_GAIN_RATE, s.gain_rate);
      write_reg(REG_GAIN_POSITION, s.gain_position);
      write_reg(REG_GAIN_VELOCITY, s.gain_velocity);
      write_reg(CSR_INDEX_WIDTH'(REG_TIME_STEP + $urandom_range(1, 8)), 16'($urandom));
      write_reg(REG_TARGET_ANGLE, s.target_angle);
      write_reg(REG_TARGET_POSITION, s.target_position);
      write_reg(REG_DRIVE_LIMIT, {1'($urandom_range(0, 1)), s.drive_limit});
      write_reg(REG_TIME_STEP, s.time_step);
      csr_valid <= 1'b0;
   endtask

   // Hold until every queued request is taken and every result is back;
   // sample at the rising edge, where the driver's outputs are settled
   task automatic wait_drained();
      while (pending_ticks.size() != 0 || req_valid || expected_drives.size() != 0)
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic run_phase(input bsfd_cfg_type s, input int count,
                            input tick_style_type style, input int idle);
      wait_drained();
      load_settings(s);
      idle_pct = idle;
      repeat (count)
         pending_ticks.push_back(random_tick(style));
   endtask

   // Request driver: hold a stalled request, otherwise idle in bursts or send the next
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && !req_taken) begin
         end else if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            send_gap <= $urandom_range(0, 2);
            req_valid <= 1'b0;
         end else if (pending_ticks.size() != 0) begin
            req_item <= pending_ticks.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result stall: random bursts at the idle percentage of the phase
   always @(negedge clock) begin
      if (!reset) begin
         if (hold_gap > 0) begin
            hold_gap <= hold_gap - 1;
            rsp_stall <= 1'b1;
         end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            hold_gap <= $urandom_range(0, 2);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Monitor: predict on each accepted request, check each accepted result
   always @(posedge clock) begin
      drive_type want;
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else if (!reset) begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall)
            expected_drives.push_back(predict_drive(req_item));
         if (rsp_valid && !rsp_stall) begin
            if (expected_drives.size() == 0) begin
               $error("unexpected result: left_drive %0d right_drive %0d limited %0b",
                      rsp_left_drive, rsp_right_drive, rsp_limited);
               fail_count++;
            end else begin
               want = expected_drives.pop_front();
               if (rsp_left_drive !== want.left_drive) begin
                  $error("left_drive: expected %0d, got %0d", want.left_drive, rsp_left_drive);
                  fail_count++;
               end
               if (rsp_right_drive !== want.right_drive) begin
                  $error("right_drive: expected %0d, got %0d",
                         want.right_drive, rsp_right_drive);
                  fail_count++;
               end
               if (rsp_limited !== want.limited) begin
                  $error("limited: expected %0b, got %0b", want.limited, rsp_limited);
                  fail_count++;
               end
            end
         end
      end
   end

   initial begin
      cfg_model.gain_angle = RST_GAIN_ANGLE;
      cfg_model.gain_rate = RST_GAIN_RATE;
      cfg_model.gain_position = RST_GAIN_POSITION;
      cfg_model.gain_velocity = RST_GAIN_VELOCITY;
      cfg_model.target_angle = RST_TARGET_ANGLE;
      cfg_model.target_position = RST_TARGET_POSITION;
      cfg_model.drive_limit = RST_DRIVE_LIMIT;
      cfg_model.time_step = RST_TIME_STEP;
      position_model = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed ticks at reset settings: field extremes, error saturation, height edge
      idle_pct = 15;
      add_tick(0, 0, 0, 0, 0, 0, 0, 0);
      add_tick(DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX, 255);
      add_tick(DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN, 0);
      add_tick(DATA_MAX, DATA_MIN, 0, 0, 0, 0, 0, 80);
      add_tick(DATA_MIN, DATA_MAX, 0, 0, 0, 0, 0, 81);
      add_tick(0, 0, 0, DATA_MAX, DATA_MAX, DATA_MIN, 0, 0);
      add_tick(0, 0, 0, DATA_MIN, DATA_MIN, DATA_MAX, 0, 0);
      add_tick(0, 0, 0, 0, 0, 0, DATA_MAX, 0);
      add_tick(0, 0, 0, 0, 0, 0, DATA_MIN, 0);
      add_tick(256, 0, 0, 0, 0, 0, 0, 80);
      add_tick(256, 0, 0, 0, 0, 0, 0, 81);
      add_tick(0, 0, DATA_MAX, 0, 0, 0, 0, 0);
      add_tick(0, 0, DATA_MIN, 0, 0, 0, 0, 0);
      add_tick(16'h5555, 16'h5555, 16'h5555, 16'h5555, 16'h5555, 16'h5555, 16'h5555, 8'h55);
      add_tick(16'hAAAA, 16'hAAAA, 16'hAAAA, 16'hAAAA, 16'hAAAA, 16'hAAAA, 16'hAAAA, 8'hAA);

      // Zero gains and a zero limit: a drive right on the bound is not flagged
      wait_drained();
      settings = '0;
      load_settings(settings);
      add_tick(0, 0, 0, 0, 0, 0, 0, 0);
      add_tick(0, 0, 0, 0, 0, 0, 256, 0);
      add_tick(0, 0, 0, 0, 0, 0, -256, 255);

      // Extreme settings, both polarities
      settings.gain_angle = 16'sh7FFF;
      settings.gain_rate = 16'sh7FFF;
      settings.gain_position = 16'sh7FFF;
      settings.gain_velocity = 16'sh7FFF;
      settings.target_angle = 16'sh8000;
      settings.target_position = 16'sh8000;
      settings.drive_limit = '1;
      settings.time_step = '1;
      run_phase(settings, 60, MIX_TICKS, 40);
      settings.gain_angle = 16'sh8000;
      settings.gain_rate = 16'sh8000;
      settings.gain_position = 16'sh8000;
      settings.gain_velocity = 16'sh8000;
      settings.target_angle = 16'sh7FFF;
      settings.target_position = 16'sh7FFF;
      settings.drive_limit = 15'd1;
      settings.time_step = '0;
      run_phase(settings, 60, MIX_TICKS, 0);

      // Random settings with a mix of ticks
      repeat (5)
         run_phase(random_settings(), 120, MIX_TICKS, 15 * $urandom_range(0, 3));

      // Wind the integrator into both saturation limits
      settings = random_settings();
      settings.time_step = '1;
      run_phase(settings, 300, CLIMB_TICKS, 15);
      run_phase(settings, 600, DESCEND_TICKS, 30);

      // Final stretch without idling
      run_phase(random_settings(), 200, MIX_TICKS, 0);

      wait_drained();
      repeat (END_SETTLE) @(posedge clock);
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
